### rtl/core/canonical_huffman_bit_decoder_unit_macros.svh
//------------------------------------------------------------------------------
// Canonical Huffman bit decoder: assertion macros
// Concurrent checks used at the end of the top level.
//------------------------------------------------------------------------------
`ifndef CANONICAL_HUFFMAN_BIT_DECODER_UNIT_MACROS_SVH
`define CANONICAL_HUFFMAN_BIT_DECODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define CHBD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chbd check failed");

// Next-cycle implication.
`define CHBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chbd check failed");

`endif

### rtl/core/chbd_pkg.sv
//------------------------------------------------------------------------------
// Canonical Huffman bit decoder: shared package
// Field widths, action, state and status codes, table entry and memory port types.
//------------------------------------------------------------------------------
package chbd_pkg;

   localparam int COUNT_W    = 9;   // codes per length
   localparam int ACC_W      = 16;  // code accumulator and first codes
   localparam int OFS_W      = 9;   // symbol offsets
   localparam int LEN_W      = 5;   // bits taken, longest length
   localparam int LEN_ADDR_W = 4;   // length table address
   localparam int SYM_W      = 8;   // symbol byte
   localparam int SYM_ADDR_W = 8;   // symbol table address
   localparam int TOTAL_W    = 9;   // declared symbol total
   localparam int SUM_W      = 13;  // sum of up to 16 counts of 511
   localparam int SLOT_W     = 18;  // free code space, up to 2^17
   localparam int CODE_W     = 18;  // running canonical code
   localparam int POS_W      = 17;  // offset plus code distance
   localparam int STATUS_W   = 3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_BUILT = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISSING   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_MISMATCH  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT    = 3'd4;

   typedef enum logic [1:0] {
      ACT_LOAD_COUNT  = 2'd0,
      ACT_LOAD_SYMBOL = 2'd1,
      ACT_BUILD       = 2'd2,
      ACT_DECODE      = 2'd3
   } act_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_BUILD_RD,
      ST_BUILD_WR,
      ST_BUILD_END,
      ST_LOOKUP,
      ST_SYMBOL
   } state_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [ACC_W-1:0]   first;
      logic [OFS_W-1:0]   offset;
   } len_entry_type;

   typedef struct packed {
      logic                  wr_en;
      logic [LEN_ADDR_W-1:0] wr_addr;
      len_entry_type         wr_data;
      logic [LEN_ADDR_W-1:0] rd_addr;
   } len_port_type;

   typedef struct packed {
      logic                  wr_en;
      logic [SYM_ADDR_W-1:0] wr_addr;
      logic [SYM_W-1:0]      wr_data;
      logic [SYM_ADDR_W-1:0] rd_addr;
   } sym_port_type;

endpackage

### rtl/core/chbd_len_table.sv
//------------------------------------------------------------------------------
// Canonical Huffman bit decoder: length table
// One entry per code length: count, first code and symbol offset.
// Registered read; an entry never written reads with a zero count.
//------------------------------------------------------------------------------
module chbd_len_table #(
   parameter int MAX_CODE_LENGTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  chbd_pkg::len_port_type  len_port,
   output chbd_pkg::len_entry_type rd_entry
);

   localparam int LIDX_W = $clog2(MAX_CODE_LENGTH);

   chbd_pkg::len_entry_type len_mem [MAX_CODE_LENGTH];

   logic [MAX_CODE_LENGTH-1:0] valid_ff;
   logic [MAX_CODE_LENGTH-1:0] valid_in;
   logic                       rd_valid_ff;
   chbd_pkg::len_entry_type    rd_data_ff;
   logic [LIDX_W-1:0]          wr_idx;
   logic [LIDX_W-1:0]          rd_idx;

   assign wr_idx = len_port.wr_addr[LIDX_W-1:0];
   assign rd_idx = len_port.rd_addr[LIDX_W-1:0];

   always_comb begin
      valid_in = valid_ff;
      if (len_port.wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (len_port.wr_en) begin
         len_mem[wr_idx] <= len_port.wr_data;
      end
      rd_data_ff <= len_mem[rd_idx];
   end

   always_comb begin
      rd_entry = rd_data_ff;
      if (!rd_valid_ff) begin
         rd_entry.count = '0;
      end
   end

endmodule

### rtl/core/chbd_sym_mem.sv
//------------------------------------------------------------------------------
// Canonical Huffman bit decoder: symbol table
// Symbols in canonical order, one write and one registered read per cycle.
//------------------------------------------------------------------------------
module chbd_sym_mem #(
   parameter int MAX_SYMBOLS = 256
) (
   input  logic                        clock,
   input  chbd_pkg::sym_port_type      sym_port,
   output logic [chbd_pkg::SYM_W-1:0]  rd_data
);

   localparam int SIDX_W = $clog2(MAX_SYMBOLS);

   logic [chbd_pkg::SYM_W-1:0] sym_mem [MAX_SYMBOLS];
   logic [chbd_pkg::SYM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (sym_port.wr_en) begin
         sym_mem[sym_port.wr_addr[SIDX_W-1:0]] <= sym_port.wr_data;
      end
      rd_data_ff <= sym_mem[sym_port.rd_addr[SIDX_W-1:0]];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/canonical_huffman_bit_decoder_unit.sv
//------------------------------------------------------------------------------
// Canonical Huffman bit decoder unit
// Request channel (req_*): one item per transfer, an action with its operands:
// load a length count, load a symbol, build the tables, or decode one bit.
// Response channel (rsp_*): exactly one result per request, in order.
// A new request is taken in the cycle after the response is written. A decode
// bit reads the length table and, when it completes a symbol, then the symbol
// table; both reads are registered. A build walks the length table, one read
// and one write per length.
// Reset clears the length counts and leaves the decoder unbuilt; symbols are
// undefined until loaded. A response held by rsp_stall stays in the output
// register; the next request is still taken and worked up to its result,
// which then waits until the output register frees.
//------------------------------------------------------------------------------
`include "canonical_huffman_bit_decoder_unit_macros.svh"

module canonical_huffman_bit_decoder_unit #(
   parameter int MAX_CODE_LENGTH = 16,
   parameter int MAX_SYMBOLS     = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_action,
   input  logic [3:0]                     req_length_slot,
   input  logic [8:0]                     req_count_value,
   input  logic [7:0]                     req_symbol_index,
   input  logic [7:0]                     req_symbol_value,
   input  logic [8:0]                     req_symbol_total,
   input  logic                           req_code_bit,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_symbol_ready,
   output logic [7:0]                     rsp_decoded_symbol,
   output logic [chbd_pkg::STATUS_W-1:0]  rsp_status
);

   localparam int LIDX_W = $clog2(MAX_CODE_LENGTH);

   // control state
   chbd_pkg::state_type state_ff, state_in;
   logic                tables_ready_ff, ready_in;
   logic [chbd_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [chbd_pkg::LEN_W-1:0] bits_taken_ff, bits_in;
   logic [chbd_pkg::ACC_W-1:0] last_code_ff, last_in;
   logic [chbd_pkg::LEN_W-1:0] longest_ff, longest_in;

   // build walk
   logic [LIDX_W-1:0]           k_ff, k_in;
   logic [chbd_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [chbd_pkg::SLOT_W-1:0] slots_ff, slots_in;
   logic [chbd_pkg::CODE_W-1:0] code_ff, code_in;
   logic                        nofit_ff, nofit_in;

   // symbol lookup
   logic [chbd_pkg::SYM_ADDR_W-1:0] pos_ff, pos_in;
   logic                            pos_ok_ff, pos_ok_in;

   // captured request
   chbd_pkg::act_type              act_ff;
   logic [3:0]                     slot_ff;
   logic [8:0]                     count_ff;
   logic [7:0]                     index_ff;
   logic [7:0]                     value_ff;
   logic [8:0]                     total_ff;
   logic                           bit_ff;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_ready_ff;
   logic [7:0]                    rsp_symbol_ff;
   logic [chbd_pkg::STATUS_W-1:0] rsp_status_ff;
   logic                          emit;
   logic                          emit_ready;
   logic [7:0]                    emit_symbol;
   logic [chbd_pkg::STATUS_W-1:0] emit_status;
   logic                          out_free;
   logic                          req_take;

   // memory ports
   chbd_pkg::len_port_type     len_port;
   chbd_pkg::len_entry_type    len_entry;
   chbd_pkg::sym_port_type     sym_port;
   logic [chbd_pkg::SYM_W-1:0] sym_data;

   // datapath terms
   logic [chbd_pkg::ACC_W-1:0]  acc_new;
   logic [chbd_pkg::LEN_W-1:0]  len_new;
   logic [chbd_pkg::ACC_W-1:0]  diff;
   logic                        hit;
   logic [chbd_pkg::POS_W-1:0]  pos;
   logic [chbd_pkg::LEN_W-1:0]  shamt;
   logic                        missing;
   logic [chbd_pkg::SLOT_W-1:0] n_slot;
   logic [chbd_pkg::CODE_W-1:0] code_plus;
   logic [chbd_pkg::CODE_W-1:0] code_last;
   logic                        mismatch;

   chbd_len_table #(
      .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
   ) u_len_table (
      .clock    (clock),
      .reset    (reset),
      .len_port (len_port),
      .rd_entry (len_entry)
   );

   chbd_sym_mem #(
      .MAX_SYMBOLS(MAX_SYMBOLS)
   ) u_sym_mem (
      .clock    (clock),
      .sym_port (sym_port),
      .rd_data  (sym_data)
   );

   assign req_stall = (state_ff != chbd_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // decode terms
   assign acc_new = {acc_ff[chbd_pkg::ACC_W-2:0], bit_ff};
   assign len_new = bits_taken_ff + chbd_pkg::LEN_W'(1);
   assign diff    = acc_new - len_entry.first;
   assign hit     = (len_entry.count != '0) && (acc_new >= len_entry.first) &&
                    (diff < chbd_pkg::ACC_W'(len_entry.count));
   assign pos     = chbd_pkg::POS_W'(len_entry.offset) + chbd_pkg::POS_W'(diff);
   assign shamt   = longest_ff - len_new;
   assign missing = (len_new >= longest_ff) || (acc_new > (last_code_ff >> shamt));

   // build terms
   assign n_slot    = chbd_pkg::SLOT_W'(len_entry.count);
   assign code_plus = code_ff + chbd_pkg::CODE_W'(len_entry.count);
   assign code_last = code_plus - chbd_pkg::CODE_W'(1);
   assign mismatch  = (sum_ff != chbd_pkg::SUM_W'(total_ff)) ||
                      (total_ff > chbd_pkg::TOTAL_W'(MAX_SYMBOLS));

   always_comb begin
      state_in    = state_ff;
      ready_in    = tables_ready_ff;
      acc_in      = acc_ff;
      bits_in     = bits_taken_ff;
      last_in     = last_code_ff;
      longest_in  = longest_ff;
      k_in        = k_ff;
      sum_in      = sum_ff;
      slots_in    = slots_ff;
      code_in     = code_ff;
      nofit_in    = nofit_ff;
      pos_in      = pos_ff;
      pos_ok_in   = pos_ok_ff;
      emit        = 1'b0;
      emit_ready  = 1'b0;
      emit_symbol = '0;
      emit_status = chbd_pkg::STATUS_OK;

      len_port.wr_en   = 1'b0;
      len_port.wr_addr = slot_ff;
      len_port.wr_data = '0;
      len_port.rd_addr = chbd_pkg::LEN_ADDR_W'(bits_taken_ff);
      sym_port.wr_en   = 1'b0;
      sym_port.wr_addr = index_ff;
      sym_port.wr_data = value_ff;
      sym_port.rd_addr = pos_ff;

      unique case (state_ff)
         chbd_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (chbd_pkg::act_type'(req_action)) inside
                  chbd_pkg::ACT_LOAD_COUNT, chbd_pkg::ACT_LOAD_SYMBOL: begin
                     state_in = chbd_pkg::ST_LOAD;
                  end
                  chbd_pkg::ACT_BUILD: begin
                     k_in       = '0;
                     sum_in     = '0;
                     slots_in   = chbd_pkg::SLOT_W'(2);
                     code_in    = '0;
                     nofit_in   = 1'b0;
                     last_in    = '0;
                     longest_in = '0;
                     state_in   = chbd_pkg::ST_BUILD_RD;
                  end
                  chbd_pkg::ACT_DECODE: begin
                     state_in = chbd_pkg::ST_LOOKUP;
                  end
                  default: begin
                     state_in = chbd_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         chbd_pkg::ST_LOAD: begin
            if (out_free) begin
               if (act_ff == chbd_pkg::ACT_LOAD_COUNT &&
                   {1'b0, slot_ff} < 5'(MAX_CODE_LENGTH)) begin
                  len_port.wr_en         = 1'b1;
                  len_port.wr_data.count = count_ff;
               end
               if (act_ff == chbd_pkg::ACT_LOAD_SYMBOL &&
                   {1'b0, index_ff} < 9'(MAX_SYMBOLS)) begin
                  sym_port.wr_en = 1'b1;
               end
               // any load invalidates the tables and drops a partial code
               ready_in = 1'b0;
               acc_in   = '0;
               bits_in  = '0;
               emit     = 1'b1;
               state_in = chbd_pkg::ST_IDLE;
            end
         end

         chbd_pkg::ST_BUILD_RD: begin
            len_port.rd_addr = chbd_pkg::LEN_ADDR_W'(k_ff);
            state_in         = chbd_pkg::ST_BUILD_WR;
         end

         chbd_pkg::ST_BUILD_WR: begin
            len_port.rd_addr        = chbd_pkg::LEN_ADDR_W'(k_ff);
            len_port.wr_en          = 1'b1;
            len_port.wr_addr        = chbd_pkg::LEN_ADDR_W'(k_ff);
            len_port.wr_data.count  = len_entry.count;
            len_port.wr_data.first  = chbd_pkg::ACC_W'(code_ff);
            len_port.wr_data.offset = chbd_pkg::OFS_W'(sum_ff);
            sum_in = sum_ff + chbd_pkg::SUM_W'(len_entry.count);
            if (!nofit_ff) begin
               if (n_slot > slots_ff) begin
                  nofit_in = 1'b1;
               end else begin
                  slots_in = (slots_ff - n_slot) << 1;
               end
            end
            if (len_entry.count != '0) begin
               last_in    = chbd_pkg::ACC_W'(code_last);
               longest_in = chbd_pkg::LEN_W'(k_ff) + chbd_pkg::LEN_W'(1);
            end
            code_in = code_plus << 1;
            if (k_ff == LIDX_W'(MAX_CODE_LENGTH - 1)) begin
               state_in = chbd_pkg::ST_BUILD_END;
            end else begin
               k_in     = k_ff + LIDX_W'(1);
               state_in = chbd_pkg::ST_BUILD_RD;
            end
         end

         chbd_pkg::ST_BUILD_END: begin
            if (out_free) begin
               if (mismatch) begin
                  emit_status = chbd_pkg::STATUS_MISMATCH;
               end else if (nofit_ff) begin
                  emit_status = chbd_pkg::STATUS_NO_FIT;
               end
               ready_in = !mismatch && !nofit_ff;
               acc_in   = '0;
               bits_in  = '0;
               emit     = 1'b1;
               state_in = chbd_pkg::ST_IDLE;
            end
         end

         chbd_pkg::ST_LOOKUP: begin
            if (!tables_ready_ff) begin
               if (out_free) begin
                  emit_status = chbd_pkg::STATUS_NOT_BUILT;
                  emit        = 1'b1;
                  state_in    = chbd_pkg::ST_IDLE;
               end
            end else if (hit) begin
               // start the symbol read now; the result goes out from ST_SYMBOL once the output register is free
               sym_port.rd_addr = chbd_pkg::SYM_ADDR_W'(pos);
               pos_in           = chbd_pkg::SYM_ADDR_W'(pos);
               pos_ok_in        = pos < chbd_pkg::POS_W'(MAX_SYMBOLS);
               state_in         = chbd_pkg::ST_SYMBOL;
            end else if (out_free) begin
               if (missing) begin
                  emit_status = chbd_pkg::STATUS_MISSING;
                  ready_in    = 1'b0;
                  acc_in      = '0;
                  bits_in     = '0;
               end else begin
                  acc_in  = acc_new;
                  bits_in = len_new;
               end
               emit     = 1'b1;
               state_in = chbd_pkg::ST_IDLE;
            end
         end

         chbd_pkg::ST_SYMBOL: begin
            if (out_free) begin
               emit_ready  = 1'b1;
               emit_symbol = pos_ok_ff ? sym_data : '0;
               acc_in      = '0;
               bits_in     = '0;
               emit        = 1'b1;
               state_in    = chbd_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = chbd_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= chbd_pkg::ST_IDLE;
         tables_ready_ff <= 1'b0;
         acc_ff          <= '0;
         bits_taken_ff   <= '0;
         last_code_ff    <= '0;
         longest_ff      <= '0;
         k_ff            <= '0;
         sum_ff          <= '0;
         slots_ff        <= '0;
         code_ff         <= '0;
         nofit_ff        <= 1'b0;
         pos_ok_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         tables_ready_ff <= ready_in;
         acc_ff          <= acc_in;
         bits_taken_ff   <= bits_in;
         last_code_ff    <= last_in;
         longest_ff      <= longest_in;
         k_ff            <= k_in;
         sum_ff          <= sum_in;
         slots_ff        <= slots_in;
         code_ff         <= code_in;
         nofit_ff        <= nofit_in;
         pos_ok_ff       <= pos_ok_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (req_take) begin
         act_ff   <= chbd_pkg::act_type'(req_action);
         slot_ff  <= req_length_slot;
         count_ff <= req_count_value;
         index_ff <= req_symbol_index;
         value_ff <= req_symbol_value;
         total_ff <= req_symbol_total;
         bit_ff   <= req_code_bit;
      end
      if (emit) begin
         rsp_ready_ff  <= emit_ready;
         rsp_symbol_ff <= emit_symbol;
         rsp_status_ff <= emit_status;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_symbol_ready   = rsp_ready_ff;
   assign rsp_decoded_symbol = rsp_symbol_ff;
   assign rsp_status         = rsp_status_ff;

   `CHBD_ASSERT_NEXT(a_take_leaves_idle, clock, reset, req_take,
                     state_ff != chbd_pkg::ST_IDLE)
   `CHBD_ASSERT_NOW(a_partial_below_longest, clock, reset, tables_ready_ff,
                    bits_taken_ff == '0 || bits_taken_ff < longest_ff)
   `CHBD_ASSERT_NOW(a_unbuilt_no_partial, clock, reset, !tables_ready_ff,
                    bits_taken_ff == '0 && acc_ff == '0)
   `CHBD_ASSERT_NOW(a_symbol_status_ok, clock, reset, rsp_valid && rsp_symbol_ready,
                    rsp_status == chbd_pkg::STATUS_OK)

endmodule
